>>> hdl/qmlu_pkg.sv
`default_nettype none
package qmlu_pkg;

    localparam int CW      = 16;          // component width, Q2.14
    localparam int FRAC    = CW - 2;
    localparam int TOLW    = 29;          // tolerance register, Q1.28
    localparam int RAWW    = 34;          // raw component, Q.28
    localparam int CRW     = 30;          // raw component rounded to Q.24
    localparam int ACW     = 29;          // its magnitude
    localparam int SQW     = 2 * ACW;
    localparam int MAGW    = 60;          // squared magnitude, Q.48
    localparam int ROOTW   = MAGW / 2;
    localparam int NUMW    = 44;          // divide numerator
    localparam int QW      = 17;          // quotient bits kept before saturation
    localparam int LANES   = 4;
    localparam int OPW     = 2;
    localparam int ALPHAW  = 15;
    localparam int WEIGHT_ONE = 16384;

    localparam logic [OPW-1:0] OP_MUL_NORM = 2'd0;
    localparam logic [OPW-1:0] OP_MUL_RAW  = 2'd1;
    localparam logic [OPW-1:0] OP_LERP     = 2'd2;
    localparam logic [OPW-1:0] OP_SPARE    = 2'd3;   // handled as raw multiply

    localparam logic [TOLW-1:0] TOL_RESET = 29'd26844;

    typedef logic signed [CW-1:0]   comp_t;
    typedef logic signed [RAWW-1:0] raw_t;

    // carried alongside the square root
    typedef struct packed {
        logic [LANES-1:0][RAWW-1:0] r;
        logic [LANES-1:0][CW-1:0]   po;
        logic                       renorm;
        logic                       tiny;
        logic                       near;
    } sq_side_t;

    // carried alongside the divider
    typedef struct packed {
        logic [LANES-1:0]         ovf;
        logic [LANES-1:0]         neg;
        logic [LANES-1:0][CW-1:0] po;
        logic                     use_div;
        logic                     ident;
    } dv_side_t;

endpackage
`default_nettype wire

>>> hdl/qmlu_isqrt.sv
`default_nettype none
module qmlu_isqrt #(
    parameter int IW = 60,
    parameter int SW = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [IW-1:0]     in_rad,
    input  wire logic [SW-1:0]     in_side,
    output logic                   out_valid,
    output logic [IW/2-1:0]        out_root,
    output logic [SW-1:0]          out_side
);
    localparam int RES = IW / 2;
    localparam int RMW = RES + 4;

    logic            v_reg    [RES];
    logic [IW-1:0]   n_reg    [RES];
    logic [RES-1:0]  root_reg [RES];
    logic [RMW-1:0]  rem_reg  [RES];
    logic [SW-1:0]   side_reg [RES];

    // one result bit per stage, restoring digit recurrence
    for (genvar k = 0; k < RES; k++) begin : g_stage
        localparam int B = RES - 1 - k;
        logic           p_v;
        logic [IW-1:0]  p_n;
        logic [RES-1:0] p_root;
        logic [RMW-1:0] p_rem;
        logic [SW-1:0]  p_side;
        logic [RMW-1:0] rem_sh, trial, rem_next;
        logic [RES-1:0] root_next;

        if (k == 0) begin : g_first
            assign p_v    = in_valid;
            assign p_n    = in_rad;
            assign p_root = '0;
            assign p_rem  = '0;
            assign p_side = in_side;
        end else begin : g_rest
            assign p_v    = v_reg[k-1];
            assign p_n    = n_reg[k-1];
            assign p_root = root_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_side = side_reg[k-1];
        end

        always_comb begin
            rem_sh = {p_rem[RMW-3:0], p_n[2*B+1 -: 2]};
            trial  = RMW'({p_root, 2'b01});
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {p_root[RES-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {p_root[RES-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= p_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k]    <= p_n;
                root_reg[k] <= root_next;
                rem_reg[k]  <= rem_next;
                side_reg[k] <= p_side;
            end
        end
    end

    assign out_valid = v_reg[RES-1];
    assign out_root  = root_reg[RES-1];
    assign out_side  = side_reg[RES-1];

endmodule
`default_nettype wire

>>> hdl/qmlu_div.sv
`default_nettype none
module qmlu_div #(
    parameter int NW    = 44,
    parameter int DW    = 30,
    parameter int QW    = 17,
    parameter int LANES = 4,
    parameter int SW    = 1
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [LANES-1:0][NW-1:0]   in_num,
    input  wire logic [DW-1:0]              in_den,
    input  wire logic [SW-1:0]              in_side,
    output logic                            out_valid,
    output logic [LANES-1:0][QW-1:0]        out_quo,
    output logic [SW-1:0]                   out_side
);
    localparam int RW = DW + QW;

    logic                           v_reg    [QW];
    logic [LANES-1:0][RW-1:0]       rem_reg  [QW];
    logic [LANES-1:0][QW-1:0]       quo_reg  [QW];
    logic [DW-1:0]                  den_reg  [QW];
    logic [SW-1:0]                  side_reg [QW];

    // one quotient bit per stage; numerator is below den << QW on entry
    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic                     p_v;
        logic [LANES-1:0][RW-1:0] p_rem;
        logic [LANES-1:0][QW-1:0] p_quo;
        logic [DW-1:0]            p_den;
        logic [SW-1:0]            p_side;
        logic [LANES-1:0][RW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0] quo_next;
        logic [RW-1:0]            dsh;

        if (k == 0) begin : g_first
            assign p_v    = in_valid;
            assign p_quo  = '0;
            assign p_den  = in_den;
            assign p_side = in_side;
            for (genvar l = 0; l < LANES; l++) begin : g_ln
                assign p_rem[l] = RW'(in_num[l]);
            end
        end else begin : g_rest
            assign p_v    = v_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_quo  = quo_reg[k-1];
            assign p_den  = den_reg[k-1];
            assign p_side = side_reg[k-1];
        end

        always_comb begin
            dsh = RW'(p_den) << B;
            for (int l = 0; l < LANES; l++) begin
                quo_next[l] = p_quo[l];
                if (p_rem[l] >= dsh) begin
                    rem_next[l]    = p_rem[l] - dsh;
                    quo_next[l][B] = 1'b1;
                end else begin
                    rem_next[l] = p_rem[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= p_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                den_reg[k]  <= p_den;
                side_reg[k] <= p_side;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
`default_nettype wire

>>> hdl/quaternion_mul_lerp_unit_top.sv
`default_nettype none
// channel   | ports                         | payload
// ----------+-------------------------------+-----------------------------------------
// input     | s_tvalid s_tready s_tdata/user| ax ay az aw bx by bz bw alpha / operation
// result    | m_tvalid m_tready m_tdata/user| rx ry rz rw / not_normalizable
// config    | cfg_valid cfg_ready cfg_data  | norm_tolerance
//
// One transaction per cycle sustained while m_tready is high. Input to result passes through
// 8 arithmetic stages, 30 square-root stages, 1 setup stage, 17 divide stages and output.
// The square root and the divide produce one bit per stage and set the depth.
// Synchronous active-low reset clears the valid bits and loads the default tolerance.
// The whole pipeline holds while a result waits on m_tready.
module quaternion_mul_lerp_unit_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (16 each), alpha (15), one zero bit
    input  wire logic [143:0]  s_tdata,
    // operation
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // r_x, r_y, r_z, r_w (16 each)
    output logic [63:0]        m_tdata,
    // not_normalizable
    output logic [0:0]         m_tuser,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [28:0]   cfg_data
);
    localparam int CW    = qmlu_pkg::CW;
    localparam int RAWW  = qmlu_pkg::RAWW;
    localparam int LANES = qmlu_pkg::LANES;

    logic en;
    logic [qmlu_pkg::TOLW-1:0] tol_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= qmlu_pkg::TOL_RESET;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: input register
    logic v1_reg;
    qmlu_pkg::comp_t a_reg [LANES];
    qmlu_pkg::comp_t b_reg [LANES];
    logic [qmlu_pkg::ALPHAW-1:0] alpha_reg;
    logic [qmlu_pkg::OPW-1:0] op1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                a_reg[i] <= s_tdata[i*CW +: CW];
                b_reg[i] <= s_tdata[(i+LANES)*CW +: CW];
            end
            alpha_reg <= s_tdata[2*LANES*CW +: qmlu_pkg::ALPHAW];
            op1_reg   <= s_tuser;
        end
    end

    // stage 2: products
    logic v2_reg;
    logic signed [31:0] p_reg  [LANES][LANES];
    logic signed [31:0] wa_reg [LANES];
    logic signed [31:0] wb_reg [LANES];
    logic [qmlu_pkg::OPW-1:0] op2_reg;
    logic signed [15:0] alpha_s, beta_s;

    always_comb begin
        alpha_s = signed'({1'b0, alpha_reg});
        beta_s  = 16'(qmlu_pkg::WEIGHT_ONE) - alpha_s;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                for (int j = 0; j < LANES; j++) begin
                    p_reg[i][j] <= a_reg[i] * b_reg[j];
                end
                wa_reg[i] <= alpha_s * a_reg[i];
                wb_reg[i] <= beta_s * b_reg[i];
            end
            op2_reg <= op1_reg;
        end
    end

    // stage 3: Hamilton sums and hemisphere dot product
    logic v3_reg;
    qmlu_pkg::raw_t ham_reg [LANES];
    logic dneg_reg;
    logic signed [31:0] wa3_reg [LANES];
    logic signed [31:0] wb3_reg [LANES];
    logic [qmlu_pkg::OPW-1:0] op3_reg;
    qmlu_pkg::raw_t dot_s;

    always_comb begin
        dot_s = RAWW'(p_reg[0][0]) + RAWW'(p_reg[1][1])
              + RAWW'(p_reg[2][2]) + RAWW'(p_reg[3][3]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ham_reg[0] <= RAWW'(p_reg[3][0]) + RAWW'(p_reg[0][3])
                        + RAWW'(p_reg[1][2]) - RAWW'(p_reg[2][1]);
            ham_reg[1] <= RAWW'(p_reg[3][1]) - RAWW'(p_reg[0][2])
                        + RAWW'(p_reg[1][3]) + RAWW'(p_reg[2][0]);
            ham_reg[2] <= RAWW'(p_reg[3][2]) + RAWW'(p_reg[0][1])
                        - RAWW'(p_reg[1][0]) + RAWW'(p_reg[2][3]);
            ham_reg[3] <= RAWW'(p_reg[3][3]) - RAWW'(p_reg[0][0])
                        - RAWW'(p_reg[1][1]) - RAWW'(p_reg[2][2]);
            dneg_reg   <= dot_s[RAWW-1];
            wa3_reg    <= wa_reg;
            wb3_reg    <= wb_reg;
            op3_reg    <= op2_reg;
        end
    end

    // stage 4: select raw components
    logic v4_reg;
    qmlu_pkg::raw_t r4_reg [LANES];
    logic renorm4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                if (op3_reg == qmlu_pkg::OP_LERP) begin
                    r4_reg[i] <= RAWW'(wa3_reg[i])
                               + (dneg_reg ? -RAWW'(wb3_reg[i]) : RAWW'(wb3_reg[i]));
                end else begin
                    r4_reg[i] <= ham_reg[i];
                end
            end
            renorm4_reg <= (op3_reg == qmlu_pkg::OP_MUL_NORM) ||
                           (op3_reg == qmlu_pkg::OP_LERP);
        end
    end

    // stage 5: round to Q.24, magnitude
    logic v5_reg;
    logic [qmlu_pkg::ACW-1:0] ac_reg [LANES];
    qmlu_pkg::raw_t r5_reg [LANES];
    logic renorm5_reg;
    logic signed [qmlu_pkg::CRW-1:0] c_s [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            c_s[i] = qmlu_pkg::CRW'((r4_reg[i] + RAWW'(8)) >>> 4);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                ac_reg[i] <= c_s[i][qmlu_pkg::CRW-1] ? qmlu_pkg::ACW'(-c_s[i])
                                                      : qmlu_pkg::ACW'(c_s[i]);
            end
            r5_reg      <= r4_reg;
            renorm5_reg <= renorm4_reg;
        end
    end

    // stage 6: squares
    logic v6_reg;
    logic [qmlu_pkg::SQW-1:0] sq_reg [LANES];
    qmlu_pkg::raw_t r6_reg [LANES];
    logic renorm6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                sq_reg[i] <= ac_reg[i] * ac_reg[i];
            end
            r6_reg      <= r5_reg;
            renorm6_reg <= renorm5_reg;
        end
    end

    // stage 7: squared magnitude
    logic v7_reg;
    logic [qmlu_pkg::MAGW-1:0] mag_reg;
    qmlu_pkg::raw_t r7_reg [LANES];
    logic renorm7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= qmlu_pkg::MAGW'(sq_reg[0]) + qmlu_pkg::MAGW'(sq_reg[1])
                     + qmlu_pkg::MAGW'(sq_reg[2]) + qmlu_pkg::MAGW'(sq_reg[3]);
            r7_reg      <= r6_reg;
            renorm7_reg <= renorm6_reg;
        end
    end

    // stage 8: tolerance tests and unnormalized output
    logic v8_reg;
    logic [qmlu_pkg::MAGW-1:0] mag8_reg;
    qmlu_pkg::sq_side_t sq8_reg;
    qmlu_pkg::sq_side_t sq8_next;
    logic [qmlu_pkg::MAGW-1:0] tol48, one48, hi48;
    logic signed [19:0] t_s;

    always_comb begin
        tol48 = qmlu_pkg::MAGW'({tol_reg, 20'b0});
        one48 = qmlu_pkg::MAGW'(1) << 48;
        hi48  = one48 + tol48;
        sq8_next.renorm = renorm7_reg;
        sq8_next.tiny   = (mag_reg < tol48) || (mag_reg == '0);
        sq8_next.near   = (mag_reg <= hi48) &&
                          ((tol48 >= one48) || (mag_reg >= one48 - tol48));
        t_s = '0;
        for (int i = 0; i < LANES; i++) begin
            sq8_next.r[i] = r7_reg[i];
            t_s = 20'((r7_reg[i] + RAWW'(8192)) >>> qmlu_pkg::FRAC);
            if (t_s > 20'sd32767) begin
                sq8_next.po[i] = 16'h7fff;
            end else if (t_s < -20'sd32768) begin
                sq8_next.po[i] = 16'h8000;
            end else begin
                sq8_next.po[i] = t_s[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag8_reg <= mag_reg;
            sq8_reg  <= sq8_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    // square root
    logic sq_v;
    logic [qmlu_pkg::ROOTW-1:0] root_s;
    qmlu_pkg::sq_side_t sq_out;

    qmlu_isqrt #(
        .IW (qmlu_pkg::MAGW),
        .SW ($bits(qmlu_pkg::sq_side_t))
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v8_reg),
        .in_rad    (mag8_reg),
        .in_side   (sq8_reg),
        .out_valid (sq_v),
        .out_root  (root_s),
        .out_side  (sq_out)
    );

    // divide setup: rounded numerator, overflow and sign per lane
    logic vd_reg;
    logic [LANES-1:0][qmlu_pkg::NUMW-1:0] num_reg;
    logic [qmlu_pkg::ROOTW-1:0] root_reg;
    qmlu_pkg::dv_side_t dv_reg;
    qmlu_pkg::dv_side_t dv_next;
    logic [LANES-1:0][qmlu_pkg::NUMW-1:0] num_next;
    logic [RAWW-2:0] ar_s;
    logic [qmlu_pkg::NUMW-1:0] n_s;

    always_comb begin
        ar_s = '0;
        n_s  = '0;
        for (int i = 0; i < LANES; i++) begin
            ar_s = sq_out.r[i][RAWW-1] ? (RAWW-1)'(-signed'(sq_out.r[i]))
                                       : sq_out.r[i][RAWW-2:0];
            n_s  = qmlu_pkg::NUMW'({ar_s, 10'b0}) + qmlu_pkg::NUMW'(root_s >> 1);
            dv_next.ovf[i] = (47'(n_s) >= {root_s, 17'b0});
            num_next[i]    = dv_next.ovf[i] ? '0 : n_s;
            dv_next.neg[i] = sq_out.r[i][RAWW-1] ^ sq_out.r[3][RAWW-1];
            dv_next.po[i]  = sq_out.po[i];
        end
        dv_next.ident   = sq_out.renorm && sq_out.tiny;
        dv_next.use_div = sq_out.renorm && !sq_out.tiny && !sq_out.near;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= sq_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg  <= num_next;
            root_reg <= root_s;
            dv_reg   <= dv_next;
        end
    end

    // divide
    logic dq_v;
    logic [LANES-1:0][qmlu_pkg::QW-1:0] quo_s;
    qmlu_pkg::dv_side_t dv_out;

    qmlu_div #(
        .NW    (qmlu_pkg::NUMW),
        .DW    (qmlu_pkg::ROOTW),
        .QW    (qmlu_pkg::QW),
        .LANES (LANES),
        .SW    ($bits(qmlu_pkg::dv_side_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vd_reg),
        .in_num    (num_reg),
        .in_den    (root_reg),
        .in_side   (dv_reg),
        .out_valid (dq_v),
        .out_quo   (quo_s),
        .out_side  (dv_out)
    );

    // output: identity, saturated quotient or unnormalized value
    logic [63:0] data_next;
    logic [qmlu_pkg::QW-1:0] negq;
    logic m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic m_tuser_reg;

    always_comb begin
        negq = '0;
        for (int i = 0; i < LANES; i++) begin
            negq = qmlu_pkg::QW'(0) - quo_s[i];
            if (dv_out.ident) begin
                data_next[i*CW +: CW] = (i == LANES - 1) ? CW'(1 << qmlu_pkg::FRAC) : '0;
            end else if (dv_out.use_div) begin
                if (dv_out.neg[i]) begin
                    if (dv_out.ovf[i] || quo_s[i] > qmlu_pkg::QW'(32768)) begin
                        data_next[i*CW +: CW] = 16'h8000;
                    end else begin
                        data_next[i*CW +: CW] = negq[CW-1:0];
                    end
                end else begin
                    if (dv_out.ovf[i] || quo_s[i] > qmlu_pkg::QW'(32767)) begin
                        data_next[i*CW +: CW] = 16'h7fff;
                    end else begin
                        data_next[i*CW +: CW] = quo_s[i][CW-1:0];
                    end
                end
            end else begin
                data_next[i*CW +: CW] = dv_out.po[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dq_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= data_next;
            m_tuser_reg <= dv_out.ident;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

>>> verif/quaternion_mul_lerp_unit_top_tb.sv
`timescale 1ns / 1ps
module quaternion_mul_lerp_unit_top_tb;

    typedef struct {
        logic [qmlu_pkg::OPW-1:0]    op;
        logic signed [15:0]          a [4];
        logic signed [15:0]          b [4];
        logic [qmlu_pkg::ALPHAW-1:0] alpha;
    } qpair_t;

    typedef struct {
        logic [63:0] q;
        logic        nn;
    } qres_t;

    localparam int DRAIN_CYCLES = 120;
    localparam longint CYCLE_LIMIT = 400000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [143:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [63:0]   m_tdata;
    logic [0:0]    m_tuser;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [28:0]   cfg_data = '0;

    logic [qmlu_pkg::TOLW-1:0] tol_model;
    qres_t           expected_q[$];
    int              n_errors = 0;
    int              n_sent = 0;
    int              n_checked = 0;
    int              n_ident = 0;
    longint          cycles = 0;
    bit              hold_ready = 1'b0;

    always #4 aclk = ~aclk;

    quaternion_mul_lerp_unit_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic [15:0] sat16(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic longint prod28(longint p, longint q);
        return p * q;   // Q.28 product of two Q2.14 values is exact
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r = 0, bt = 64'h4000_0000_0000_0000;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= r + bt) begin
                n -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic qres_t identity_res();
        qres_t o;
        o.q = {16'sd16384, 48'd0};
        o.nn = 1'b1;
        return o;
    endfunction

    function automatic qres_t renorm_quat(longint r[4]);
        qres_t o;
        longint unsigned mag = 0, root, an, qt;
        longint tol48, one48, c, num;
        bit neg;
        one48 = longint'(1) << 48;
        tol48 = longint'(tol_model) << 20;
        for (int i = 0; i < 4; i++) begin
            c = rnd_shift(r[i], 4);
            if (c < 0) c = -c;
            mag += longint'(c) * c;
        end
        if (longint'(mag) < tol48) return identity_res();
        if (longint'(mag) > one48 + tol48 || longint'(mag) < one48 - tol48) begin
            root = int_sqrt(mag);
            if (root == 0) return identity_res();
            for (int i = 0; i < 4; i++) begin
                num = r[i] * 1024;
                neg = (num < 0) != (r[3] < 0);
                an = num < 0 ? -num : num;
                qt = (an + root / 2) / root;
                o.q[16*i +: 16] = sat16(neg ? -longint'(qt) : longint'(qt));
            end
        end else begin
            for (int i = 0; i < 4; i++) o.q[16*i +: 16] = sat16(rnd_shift(r[i], 14));
        end
        o.nn = 1'b0;
        return o;
    endfunction

    function automatic qres_t predict_quat(qpair_t it);
        longint a[4], b[4], r[4], dot, al, be;
        qres_t o;
        for (int i = 0; i < 4; i++) begin
            a[i] = it.a[i];
            b[i] = it.b[i];
        end
        if (it.op == qmlu_pkg::OP_LERP) begin
            al = it.alpha;
            be = qmlu_pkg::WEIGHT_ONE - al;
            dot = 0;
            for (int i = 0; i < 4; i++) dot += prod28(a[i], b[i]);
            if (dot < 0) be = -be;
            for (int i = 0; i < 4; i++) r[i] = al * a[i] + be * b[i];
            return renorm_quat(r);
        end
        r[0] = a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1];
        r[1] = a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0];
        r[2] = a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3];
        r[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
        if (it.op == qmlu_pkg::OP_MUL_NORM) return renorm_quat(r);
        for (int i = 0; i < 4; i++) o.q[16*i +: 16] = sat16(rnd_shift(r[i], 14));
        o.nn = 1'b0;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
    endtask

    // valid stays up across back-to-back transactions; dropped only for a gap
    task automatic send_pair(qpair_t it);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        expected_q.push_back(predict_quat(it));
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {1'b0, it.alpha, it.b[3], it.b[2], it.b[1], it.b[0],
                    it.a[3], it.a[2], it.a[1], it.a[0]};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tolerance(logic [qmlu_pkg::TOLW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tol_model = v;
    endtask

    // random pair: components drawn at one of four amplitudes, full range included
    function automatic qpair_t random_pair(int shape);
        qpair_t it;
        int amp;
        it.op = qmlu_pkg::OPW'($urandom_range(0, 3));
        it.alpha = qmlu_pkg::ALPHAW'(($urandom_range(0, 9) == 0) ? $urandom
                                                                  : $urandom_range(0, 16384));
        amp = (shape == 0) ? 65535 : (shape == 1) ? 8192 : (shape == 2) ? 64 : 20000;
        for (int i = 0; i < 4; i++) begin
            if (amp == 65535) begin
                it.a[i] = 16'($urandom);
                it.b[i] = 16'($urandom);
            end else begin
                it.a[i] = 16'(int'($urandom_range(0, 2*amp)) - amp);
                it.b[i] = 16'(int'($urandom_range(0, 2*amp)) - amp);
            end
        end
        if (shape == 3 && $urandom_range(0, 1)) it.b[3] = -it.a[3];
        return it;
    endfunction

    function automatic qpair_t make_pair(logic [1:0] op, int ax, int ay, int az, int aw,
                                        int bx, int by, int bz, int bw, int al);
        qpair_t it;
        it.op = op;
        it.a = '{16'(ax), 16'(ay), 16'(az), 16'(aw)};
        it.b = '{16'(bx), 16'(by), 16'(bz), 16'(bw)};
        it.alpha = qmlu_pkg::ALPHAW'(al);
        return it;
    endfunction

    task automatic test_directed();
        logic [1:0] ops[4] = '{qmlu_pkg::OP_MUL_NORM, qmlu_pkg::OP_MUL_RAW,
                               qmlu_pkg::OP_LERP, qmlu_pkg::OP_SPARE};
        foreach (ops[k]) begin
            send_pair(make_pair(ops[k], 0, 0, 0, 16384, 0, 0, 0, 16384, 8192));
            send_pair(make_pair(ops[k], 32767, 32767, 32767, 32767,
                                32767, 32767, 32767, 32767, 16384));
            send_pair(make_pair(ops[k], -32768, -32768, -32768, -32768,
                                32767, -32768, 32767, -32768, 0));
            send_pair(make_pair(ops[k], 0, 0, 0, 0, 0, 0, 0, 0, 16384));
        end
        // shortest path: opposite hemispheres, zero weight, weight above one
        send_pair(make_pair(qmlu_pkg::OP_LERP, 0, 0, 0, 16384, 0, 0, 0, -16384, 8192));
        send_pair(make_pair(qmlu_pkg::OP_LERP, 11585, 0, 0, 11585, 0, 11585, 0, -11585, 0));
        send_pair(make_pair(qmlu_pkg::OP_LERP, 100, -200, 300, 16384, 5, 5, 5, 16000, 32767));
        send_pair(make_pair(qmlu_pkg::OP_MUL_NORM, 1, 0, 0, 1, 1, 0, 0, 1, 0));
        send_pair(make_pair(qmlu_pkg::OP_MUL_NORM, 0, 0, 0, -8192, 0, 0, 0, 8192, 0));
        send_pair(make_pair(qmlu_pkg::OP_MUL_NORM, 100, 0, 0, -16380, 0, 0, 0, 16384, 0));
        wait_drained();
    endtask

    task automatic test_random(int count);
        qpair_t it;
        for (int k = 0; k < count; k++) begin
            it = random_pair($urandom_range(0, 3));
            send_pair(it);
            if (it.op == qmlu_pkg::OP_LERP || it.op == qmlu_pkg::OP_MUL_NORM) n_ident++;
        end
    endtask

    task automatic test_tolerance_sweep();
        logic [qmlu_pkg::TOLW-1:0] tols[4] = '{29'd0, 29'd268435456, 29'h1fffffff,
                                               29'd1 << 20};
        foreach (tols[k]) begin
            wait_drained();
            write_tolerance(tols[k]);
            for (int j = 0; j < 8; j++)
                send_pair(make_pair(qmlu_pkg::OP_MUL_NORM, 0, 0, 0, j, 0, 0, 0, j, 0));
            test_random(130);
        end
        wait_drained();
        write_tolerance(qmlu_pkg::TOL_RESET);
    endtask

    task automatic test_backpressure_pause();
        test_random(60);
        wait_drained();
        hold_ready = 1'b1;
        test_random(40);
        hold_ready = 1'b0;
        wait_drained();
    endtask

    // result side: random stalls, with stretches of constant ready
    always @(posedge aclk) begin
        qres_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, '0);
            end else begin
                w = expected_q.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_tdata[16*i +: 16] !== w.q[16*i +: 16])
                        report_mismatch($sformatf("component %0d", i),
                                        64'(m_tdata[16*i +: 16]), 64'(w.q[16*i +: 16]));
                if (m_tuser[0] !== w.nn)
                    report_mismatch("not_normalizable", 64'(m_tuser), 64'(w.nn));
            end
            n_checked++;
        end
    end

    initial begin
        int stall;
        forever begin
            stall = (hold_ready || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        tol_model = qmlu_pkg::TOL_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(500);
        test_tolerance_sweep();
        test_backpressure_pause();
        test_random(150);
        wait_drained();
        $display("sent %0d quaternion pairs, checked %0d results", n_sent, n_checked);
        $display("covered all operations, five tolerance settings and output stalls");
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/qmlu_pkg.sv
hdl/qmlu_isqrt.sv
hdl/qmlu_div.sv
hdl/quaternion_mul_lerp_unit_top.sv
verif/quaternion_mul_lerp_unit_top_tb.sv
